### rtl/pdga_pkg.sv
// Package for the Poisson-disk grid acceptor: widths, codes and shared types.
// Used by every module in rtl/; depends on nothing else.
package pdga_pkg;

   localparam int GRID_MAX_DIM    = 64;
   localparam int NEIGHBOUR_REACH = 2;
   localparam int DIM_W           = $clog2(GRID_MAX_DIM);
   localparam int CELL_ADDR_W     = 2 * DIM_W;
   localparam int CELL_COUNT      = GRID_MAX_DIM * GRID_MAX_DIM;

   localparam int COORD_W    = 16;
   localparam int RECIP_W    = 24;
   localparam int PROD_W     = COORD_W + RECIP_W;
   localparam int CELL_SHIFT = 24;
   localparam int CELL_Q_W   = PROD_W - CELL_SHIFT;
   localparam int DIST_W     = 32;
   localparam int DIM_CFG_W  = 7;
   localparam int FIELD_W    = 6;
   localparam int FIELD_MAX  = (1 << FIELD_W) - 1;
   localparam int POINT_W    = 2 * COORD_W;
   localparam int ENTRY_W    = POINT_W + 1;

   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST_SQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_RECIP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS   = 2'd3;

   localparam logic [RECIP_W-1:0]   RECIP_RESET = 24'd65536;
   localparam logic [DIM_CFG_W-1:0] DIM_RESET   = 7'd64;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR,
      MODE_TEST,
      MODE_TEST_INSERT,
      MODE_INSERT
   } mode_type;

   typedef struct packed {
      logic                done;
      logic [CELL_Q_W-1:0] col;
      logic [CELL_Q_W-1:0] row;
   } cell_result_type;

   typedef struct packed {
      logic busy;
      logic near;
   } dist_status_type;

endpackage

### rtl/poisson_disk_grid_acceptor_core.sv
// Top level of the Poisson-disk grid acceptor: sequencer, grid memory and
// configuration registers. Depends on pdga_pkg, pdga_cell_unit, pdga_dist_unit.
//
// The request channel carries one word per candidate point: req_tuser holds the
// mode (clear grid, test, test and insert, insert always) and req_tdata the
// point. The response channel returns one word per request with the accept
// and out-of-grid flags and the point's cell. Registers are written through
// csr_we, csr_index and csr_wdata; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
// A test request first finds its cell in the unit that finds the cell, then
// reads the neighbor cells of the 5x5 window (up to 25, clipped at the grid's
// edges) from the grid memory one after another, drains the distance unit and
// posts the result. The next request is accepted only once the result is
// posted: req_tready rises in the same cycle as rsp_tvalid. A point outside
// the grid skips the scan and answers once its cell is known.
// A clear request sweeps the 4096-entry grid memory one entry per cycle and
// then answers. After reset the same sweep runs before the first request is
// accepted; register writes are taken at once. A finished response waits in
// an output register, so one more request is accepted while the receiver
// stalls; its response then waits until the earlier one has been taken.
module poisson_disk_grid_acceptor_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // point_x [15:0], point_y [31:16]
   input  logic [pdga_pkg::REQ_DATA_W-1:0]       req_tdata,
   // mode [1:0]
   input  logic [pdga_pkg::MODE_W-1:0]           req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted [0], out_of_grid [1], cell_column [7:2], cell_row [13:8], zeros
   output logic [pdga_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [pdga_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pdga_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_INDEX,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                                 state_ff, state_in;
   pdga_pkg::mode_type                        mode_ff, mode_in;
   logic [pdga_pkg::COORD_W-1:0]              px_ff, px_in, py_ff, py_in;
   logic                                      start_ff, start_in;
   logic [pdga_pkg::FIELD_W-1:0]              col_ff, col_in, row_ff, row_in;
   logic [pdga_pkg::DIM_W-1:0]                gcol_ff, gcol_in, grow_ff, grow_in;
   logic                                      outside_ff, outside_in;
   logic [pdga_pkg::DIM_W-1:0]                c_ff, c_in, r_ff, r_in;
   logic [pdga_pkg::DIM_W-1:0]                c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [pdga_pkg::CELL_ADDR_W-1:0]          sweep_ff, sweep_in;
   logic                                      sweep_item_ff, sweep_item_in;
   logic                                      res_acc_ff, res_acc_in;
   logic                                      res_oog_ff, res_oog_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic                                      rsp_acc_ff, rsp_acc_in;
   logic                                      rsp_oog_ff, rsp_oog_in;
   logic [pdga_pkg::FIELD_W-1:0]              rsp_col_ff, rsp_col_in;
   logic [pdga_pkg::FIELD_W-1:0]              rsp_row_ff, rsp_row_in;
   logic [pdga_pkg::DIST_W-1:0]               min_sq_ff, min_sq_in;
   logic [pdga_pkg::RECIP_W-1:0]              recip_ff, recip_in;
   logic [pdga_pkg::DIM_CFG_W-1:0]            cols_ff, cols_in, rows_ff, rows_in;

   logic [pdga_pkg::ENTRY_W-1:0]              grid_mem [pdga_pkg::CELL_COUNT];
   logic [pdga_pkg::ENTRY_W-1:0]              rdata_ff;
   logic                                      rd_vld_ff;
   logic                                      mem_we, mem_re;
   logic [pdga_pkg::CELL_ADDR_W-1:0]          mem_waddr, mem_raddr;
   logic [pdga_pkg::ENTRY_W-1:0]              mem_wdata;

   pdga_pkg::cell_result_type                 cell_res;
   pdga_pkg::dist_status_type                 dist_st;
   logic                                      dist_clear;

   logic [pdga_pkg::DIM_CFG_W-1:0]            cols_eff, rows_eff, col_lim, row_lim;
   logic [pdga_pkg::DIM_CFG_W-1:0]            col_hi, row_hi;
   logic [pdga_pkg::DIM_W-1:0]                ncol, nrow;
   logic                                      outside_now, accept_now;

   pdga_cell_unit u_cell (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .point_x    (px_ff),
      .point_y    (py_ff),
      .cell_recip (recip_ff),
      .result     (cell_res)
   );

   pdga_dist_unit u_dist (
      .clock           (clock),
      .reset           (reset),
      .clear           (dist_clear),
      .entry_valid     (rd_vld_ff && rdata_ff[pdga_pkg::ENTRY_W-1]),
      .entry_point     (rdata_ff[pdga_pkg::POINT_W-1:0]),
      .point_x         (px_ff),
      .point_y         (py_ff),
      .min_distance_sq (min_sq_ff),
      .status          (dist_st)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pdga_pkg::RSP_DATA_W - 2 * pdga_pkg::FIELD_W - 2){1'b0}},
                        rsp_row_ff, rsp_col_ff, rsp_oog_ff, rsp_acc_ff};

   assign cols_eff = (cols_ff > pdga_pkg::DIM_CFG_W'(pdga_pkg::GRID_MAX_DIM)) ?
                     pdga_pkg::DIM_CFG_W'(pdga_pkg::GRID_MAX_DIM) : cols_ff;
   assign rows_eff = (rows_ff > pdga_pkg::DIM_CFG_W'(pdga_pkg::GRID_MAX_DIM)) ?
                     pdga_pkg::DIM_CFG_W'(pdga_pkg::GRID_MAX_DIM) : rows_ff;
   assign col_lim  = cols_eff - 1'b1;
   assign row_lim  = rows_eff - 1'b1;
   assign ncol     = cell_res.col[pdga_pkg::DIM_W-1:0];
   assign nrow     = cell_res.row[pdga_pkg::DIM_W-1:0];
   assign col_hi   = pdga_pkg::DIM_CFG_W'(ncol) +
                     pdga_pkg::DIM_CFG_W'(pdga_pkg::NEIGHBOUR_REACH);
   assign row_hi   = pdga_pkg::DIM_CFG_W'(nrow) +
                     pdga_pkg::DIM_CFG_W'(pdga_pkg::NEIGHBOUR_REACH);
   assign outside_now = (cell_res.col >= pdga_pkg::CELL_Q_W'(cols_eff)) ||
                        (cell_res.row >= pdga_pkg::CELL_Q_W'(rows_eff));
   assign accept_now  = !dist_st.near;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      start_in      = 1'b0;
      col_in        = col_ff;
      row_in        = row_ff;
      gcol_in       = gcol_ff;
      grow_in       = grow_ff;
      outside_in    = outside_ff;
      c_in          = c_ff;
      r_in          = r_ff;
      c1_in         = c1_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      sweep_in      = sweep_ff;
      sweep_item_in = sweep_item_ff;
      res_acc_in    = res_acc_ff;
      res_oog_in    = res_oog_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_oog_in    = rsp_oog_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      min_sq_in     = min_sq_ff;
      recip_in      = recip_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = {r_ff, c_ff};
      dist_clear    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            pdga_pkg::CSR_MIN_DIST_SQ: min_sq_in = csr_wdata[pdga_pkg::DIST_W-1:0];
            pdga_pkg::CSR_CELL_RECIP:  recip_in  = csr_wdata[pdga_pkg::RECIP_W-1:0];
            pdga_pkg::CSR_GRID_COLS:   cols_in   = csr_wdata[pdga_pkg::DIM_CFG_W-1:0];
            pdga_pkg::CSR_GRID_ROWS:   rows_in   = csr_wdata[pdga_pkg::DIM_CFG_W-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               sweep_item_in = 1'b0;
               state_in      = sweep_item_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = pdga_pkg::mode_type'(req_tuser);
               px_in   = req_tdata[pdga_pkg::COORD_W-1:0];
               py_in   = req_tdata[pdga_pkg::POINT_W-1:pdga_pkg::COORD_W];
               if (pdga_pkg::mode_type'(req_tuser) == pdga_pkg::MODE_CLEAR) begin
                  sweep_in      = '0;
                  sweep_item_in = 1'b1;
                  col_in        = '0;
                  row_in        = '0;
                  res_acc_in    = 1'b0;
                  res_oog_in    = 1'b0;
                  state_in      = ST_SWEEP;
               end else begin
                  start_in   = 1'b1;
                  dist_clear = 1'b1;
                  state_in   = ST_INDEX;
               end
            end
         end
         ST_INDEX: begin
            if (cell_res.done) begin
               col_in     = (cell_res.col > pdga_pkg::CELL_Q_W'(pdga_pkg::FIELD_MAX)) ?
                            pdga_pkg::FIELD_W'(pdga_pkg::FIELD_MAX) :
                            cell_res.col[pdga_pkg::FIELD_W-1:0];
               row_in     = (cell_res.row > pdga_pkg::CELL_Q_W'(pdga_pkg::FIELD_MAX)) ?
                            pdga_pkg::FIELD_W'(pdga_pkg::FIELD_MAX) :
                            cell_res.row[pdga_pkg::FIELD_W-1:0];
               gcol_in    = ncol;
               grow_in    = nrow;
               outside_in = outside_now;
               c_in       = (ncol >= pdga_pkg::DIM_W'(pdga_pkg::NEIGHBOUR_REACH)) ?
                            ncol - pdga_pkg::DIM_W'(pdga_pkg::NEIGHBOUR_REACH) : '0;
               r0_in      = (nrow >= pdga_pkg::DIM_W'(pdga_pkg::NEIGHBOUR_REACH)) ?
                            nrow - pdga_pkg::DIM_W'(pdga_pkg::NEIGHBOUR_REACH) : '0;
               r_in       = r0_in;
               c1_in      = (col_hi > col_lim) ? col_lim[pdga_pkg::DIM_W-1:0] :
                            col_hi[pdga_pkg::DIM_W-1:0];
               r1_in      = (row_hi > row_lim) ? row_lim[pdga_pkg::DIM_W-1:0] :
                            row_hi[pdga_pkg::DIM_W-1:0];
               if (outside_now) begin
                  res_acc_in = 1'b0;
                  res_oog_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  res_oog_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_re = 1'b1;
            if (r_ff == r1_ff) begin
               r_in = r0_ff;
               if (c_ff == c1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !dist_st.busy) begin
               res_acc_in = accept_now;
               if ((mode_ff == pdga_pkg::MODE_INSERT) ||
                   ((mode_ff == pdga_pkg::MODE_TEST_INSERT) && accept_now)) begin
                  mem_we    = 1'b1;
                  mem_waddr = {grow_ff, gcol_ff};
                  mem_wdata = {1'b1, py_ff, px_ff};
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_oog_in   = res_oog_ff;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         sweep_item_ff <= 1'b0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_sq_ff     <= '0;
         recip_ff      <= pdga_pkg::RECIP_RESET;
         cols_ff       <= pdga_pkg::DIM_RESET;
         rows_ff       <= pdga_pkg::DIM_RESET;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sweep_item_ff <= sweep_item_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_sq_ff     <= min_sq_in;
         recip_ff      <= recip_in;
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         mode_ff       <= mode_in;
         px_ff         <= px_in;
         py_ff         <= py_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         gcol_ff       <= gcol_in;
         grow_ff       <= grow_in;
         outside_ff    <= outside_in;
         c_ff          <= c_in;
         r_ff          <= r_in;
         c1_ff         <= c1_in;
         r0_ff         <= r0_in;
         r1_ff         <= r1_in;
         res_acc_ff    <= res_acc_in;
         res_oog_ff    <= res_oog_in;
         rsp_acc_ff    <= rsp_acc_in;
         rsp_oog_ff    <= rsp_oog_in;
         rsp_col_ff    <= rsp_col_in;
         rsp_row_ff    <= rsp_row_in;
      end
   end

   // Each entry holds the stored point with its valid flag in the top bit.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= grid_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= mem_re;
      end
   end

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("grid memory written outside sweep or insert");

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (c_ff <= c1_ff && r_ff <= r1_ff && r0_ff <= r_ff))
      else $error("scan left its neighbor window");

   a_no_insert_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && mem_we) |-> !outside_ff)
      else $error("insert of a point outside the grid");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_acc_ff && rsp_oog_ff))
      else $error("out-of-grid point reported as accepted");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_INDEX || state_ff == ST_SWEEP))
      else $error("accepted word did not start processing");

endmodule

### rtl/pdga_cell_unit.sv
// Cell index unit: one shared 16x24 multiplier turns x, then y, into grid cells.
// Depends on pdga_pkg.
module pdga_cell_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pdga_pkg::COORD_W-1:0]          point_x,
   input  logic [pdga_pkg::COORD_W-1:0]          point_y,
   input  logic [pdga_pkg::RECIP_W-1:0]          cell_recip,
   output pdga_pkg::cell_result_type             result
);

   typedef enum logic [1:0] {
      CU_IDLE,
      CU_MUL_X,
      CU_MUL_Y,
      CU_FIN
   } step_type;

   step_type                          step_ff, step_in;
   logic [pdga_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [pdga_pkg::CELL_Q_W-1:0]     col_ff, col_in;
   logic [pdga_pkg::COORD_W-1:0]      operand;
   logic [pdga_pkg::PROD_W-1:0]       product;

   assign operand = (step_ff == CU_MUL_Y) ? point_y : point_x;
   assign product = pdga_pkg::PROD_W'(operand) * pdga_pkg::PROD_W'(cell_recip);

   always_comb begin
      step_in = step_ff;
      prod_in = prod_ff;
      col_in  = col_ff;
      case (step_ff)
         CU_IDLE: begin
            if (start) begin
               step_in = CU_MUL_X;
            end
         end
         CU_MUL_X: begin
            prod_in = product;
            step_in = CU_MUL_Y;
         end
         CU_MUL_Y: begin
            col_in  = prod_ff[pdga_pkg::PROD_W-1 -: pdga_pkg::CELL_Q_W];
            prod_in = product;
            step_in = CU_FIN;
         end
         CU_FIN: begin
            step_in = CU_IDLE;
         end
         default: begin
            step_in = CU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= CU_IDLE;
      end else begin
         step_ff <= step_in;
         prod_ff <= prod_in;
         col_ff  <= col_in;
      end
   end

   assign result.done = (step_ff == CU_FIN);
   assign result.col  = col_ff;
   assign result.row  = prod_ff[pdga_pkg::PROD_W-1 -: pdga_pkg::CELL_Q_W];

endmodule

### rtl/pdga_dist_unit.sv
// Distance unit: squares the offsets to one stored point a cycle and flags any
// point closer than the minimum spacing. Depends on pdga_pkg.
module pdga_dist_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  entry_valid,
   input  logic [pdga_pkg::POINT_W-1:0]          entry_point,
   input  logic [pdga_pkg::COORD_W-1:0]          point_x,
   input  logic [pdga_pkg::COORD_W-1:0]          point_y,
   input  logic [pdga_pkg::DIST_W-1:0]           min_distance_sq,
   output pdga_pkg::dist_status_type             status
);

   logic                              s1_vld_ff;
   logic                              near_ff, near_in;
   logic [pdga_pkg::DIST_W-1:0]       sqx_ff, sqy_ff;
   logic [pdga_pkg::COORD_W-1:0]      sx, sy, dx, dy;
   logic [pdga_pkg::DIST_W:0]         sum;

   assign sx  = entry_point[pdga_pkg::COORD_W-1:0];
   assign sy  = entry_point[pdga_pkg::POINT_W-1:pdga_pkg::COORD_W];
   assign dx  = (point_x >= sx) ? point_x - sx : sx - point_x;
   assign dy  = (point_y >= sy) ? point_y - sy : sy - point_y;
   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      near_in = near_ff;
      if (clear) begin
         near_in = 1'b0;
      end else if (s1_vld_ff && (sum < {1'b0, min_distance_sq})) begin
         near_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         near_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= entry_valid;
         near_ff   <= near_in;
         sqx_ff    <= pdga_pkg::DIST_W'(dx) * pdga_pkg::DIST_W'(dx);
         sqy_ff    <= pdga_pkg::DIST_W'(dy) * pdga_pkg::DIST_W'(dy);
      end
   end

   assign status.busy = s1_vld_ff;
   assign status.near = near_ff;

endmodule
